@@ rtl/core/stdt_pkg.sv @@
package stdt_pkg;

  localparam int TABLE_ENTRIES  = 1024;
  localparam int MAX_TAIL_BASES = 23;
  localparam int IDX_W          = $clog2(TABLE_ENTRIES);
  localparam int CNT_W          = IDX_W + 1;
  localparam int CODE_W         = 46;
  localparam int LEN_W          = 5;
  localparam int ENTRY_W        = LEN_W + CODE_W;
  localparam int POS_W          = 11;
  localparam int BYTES_W        = 13;
  localparam int IN_W           = 56;
  localparam int OUT_W          = 40;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_LOAD   = 2'd1,
    OP_FIND   = 2'd2,
    OP_CREATE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_EMPTY     = 3'd0,
    ST_FOUND     = 3'd1,
    ST_CREATED   = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4,
    ST_LOADED    = 3'd5,
    ST_REJECTED  = 3'd6,
    ST_CLEARED   = 3'd7
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DONE
  } state_t;

  typedef struct packed {
    logic               we;
    logic [IDX_W-1:0]   waddr;
    logic [ENTRY_W-1:0] wdata;
    logic               re;
    logic [IDX_W-1:0]   raddr;
  } mem_req_t;

  typedef struct packed {
    logic [BYTES_W-1:0] packed_bytes;
    logic               dirty;
    logic [POS_W-1:0]   total_tails;
    status_t            status;
    logic [POS_W-1:0]   position;
  } result_t;

  // Bits kept for a tail of len bases: two per base.
  function automatic logic [CODE_W-1:0] code_mask(logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] m;
    for (int i = 0; i < CODE_W; i++) begin
      m[i] = (6'(i) < {len, 1'b0});
    end
    return m;
  endfunction

  // One length byte plus the packed bases.
  function automatic logic [2:0] tail_bytes(logic [LEN_W-1:0] len);
    logic [LEN_W:0] s;
    s = {1'b0, len} + (LEN_W+1)'(7);
    return s[4:2];
  endfunction

endpackage

@@ rtl/core/stdt_store.sv @@
module stdt_store
  import stdt_pkg::*;
(
  input  logic               clk,
  input  mem_req_t           req,
  output logic [ENTRY_W-1:0] rd_data
);

  logic [ENTRY_W-1:0] mem [TABLE_ENTRIES];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

@@ rtl/core/stdt_ctrl.sv @@
module stdt_ctrl
  import stdt_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [IN_W-1:0]    in_data,
  output mem_req_t           mem_req,
  input  logic [ENTRY_W-1:0] rd_data,
  output logic               res_valid,
  input  logic               res_take,
  output result_t            res
);

  state_t state, state_next;

  logic [CNT_W-1:0]   loaded_count;
  logic [CNT_W-1:0]   created_count;
  logic [BYTES_W-1:0] byte_total;
  logic [ENTRY_W-1:0] key;
  logic               is_create;
  logic [CNT_W-1:0]   issue_idx;
  logic               pending;
  logic [IDX_W-1:0]   rd_idx;
  logic [POS_W-1:0]   res_pos;
  status_t            res_status;

  op_t               in_op;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic              accept;
  logic [CNT_W-1:0]  total;
  logic              full;
  logic              load_ok;
  logic              scan_hit;
  logic              scan_end;
  logic              create_ok;

  assign in_op   = op_t'(in_data[1:0]);
  assign in_code = in_data[47:2];
  assign in_len  = in_data[52:48];
  assign accept  = in_valid && in_ready;
  assign total   = loaded_count + created_count;
  assign full    = total >= CNT_W'(TABLE_ENTRIES);
  assign load_ok = (created_count == '0) && (in_len <= LEN_W'(MAX_TAIL_BASES)) && !full;
  assign scan_hit  = (state == S_SCAN) && pending && (rd_data == key);
  assign scan_end  = (state == S_SCAN) && !pending && (issue_idx == total) && !scan_hit;
  assign create_ok = scan_end && is_create && !full;

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          if ((in_op == OP_FIND || in_op == OP_CREATE) && in_len != '0 &&
              in_len <= LEN_W'(MAX_TAIL_BASES)) begin
            state_next = S_SCAN;
          end else begin
            state_next = S_DONE;
          end
        end
      end
      S_SCAN: begin
        if (scan_hit || scan_end) begin
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (res_take) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready  = (state == S_IDLE);
    res_valid = (state == S_DONE);
    mem_req   = '0;
    if (accept && in_op == OP_LOAD && load_ok) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = total[IDX_W-1:0];
      mem_req.wdata = {in_len, in_code};
    end else if (create_ok) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = total[IDX_W-1:0];
      mem_req.wdata = key;
    end
    if (state == S_SCAN && !scan_hit && issue_idx < total) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = issue_idx[IDX_W-1:0];
    end
    res.position     = res_pos;
    res.status       = res_status;
    res.total_tails  = POS_W'(total);
    res.dirty        = (created_count != '0);
    res.packed_bytes = byte_total;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      loaded_count  <= '0;
      created_count <= '0;
      byte_total    <= '0;
      pending       <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        unique case (in_op)
          OP_CLEAR: begin
            loaded_count  <= '0;
            created_count <= '0;
            byte_total    <= '0;
          end
          OP_LOAD: begin
            if (load_ok) begin
              loaded_count <= loaded_count + CNT_W'(1);
              byte_total   <= byte_total + BYTES_W'(tail_bytes(in_len));
            end
          end
          default: begin
            pending <= 1'b0;
          end
        endcase
      end
      if (state == S_SCAN) begin
        pending <= mem_req.re;
      end
      if (create_ok) begin
        created_count <= created_count + CNT_W'(1);
        byte_total    <= byte_total + BYTES_W'(tail_bytes(key[ENTRY_W-1:CODE_W]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      key       <= {in_len, (in_op == OP_CREATE) ? (in_code & code_mask(in_len)) : in_code};
      is_create <= (in_op == OP_CREATE);
      issue_idx <= '0;
      res_pos   <= '0;
      unique case (in_op)
        OP_CLEAR: res_status <= ST_CLEARED;
        OP_LOAD: begin
          if (created_count != '0 || in_len > LEN_W'(MAX_TAIL_BASES)) begin
            res_status <= ST_REJECTED;
          end else if (full) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_LOADED;
            res_pos    <= POS_W'(total + CNT_W'(1));
          end
        end
        default: begin
          res_status <= (in_len == '0) ? ST_EMPTY : ST_NOT_FOUND;
        end
      endcase
    end
    if (mem_req.re) begin
      issue_idx <= issue_idx + CNT_W'(1);
      rd_idx    <= issue_idx[IDX_W-1:0];
    end
    if (scan_hit) begin
      res_status <= ST_FOUND;
      res_pos    <= POS_W'({1'b0, rd_idx} + CNT_W'(1));
    end else if (scan_end) begin
      if (!is_create) begin
        res_status <= ST_NOT_FOUND;
      end else if (full) begin
        res_status <= ST_FULL;
      end else begin
        res_status <= ST_CREATED;
        res_pos    <= POS_W'(total + CNT_W'(1));
      end
    end
  end

endmodule

@@ rtl/core/sequence_tail_dedup_table.sv @@
// Tail dedup table: one result word per input word.
// Input stream s_*: tdata = op[1:0], base_bits[47:2], tail_length[52:48].
//   op 0 clears the counts, 1 appends a loaded tail, 2 finds, 3 finds or creates.
// Output stream m_*: tdata = position[10:0], status[13:11], total_tails[24:14],
//   dirty[25], packed_bytes[38:26].
// One word is worked on at a time. Clear, load and a find or find-or-create
// with a zero or overlong tail length go from accept straight to the result
// register; the others scan the stored tails one per cycle out of a table
// with a registered read, and finish early when a match turns up.
// A finished result sits in the output register; the next input word is
// accepted while it waits. If the receiver holds m_tready low, the block
// stalls only once a second result is ready and the register is still full.
// Synchronous reset empties the table counts and the output register; the
// table contents are not cleared and are never read beyond the stored count.
module sequence_tail_dedup_table
  import stdt_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // op, base_bits, tail_length
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata    // position, status, total_tails, dirty, packed_bytes
);

  mem_req_t           mem_req;
  logic [ENTRY_W-1:0] rd_data;
  logic               res_valid;
  logic               res_take;
  result_t            res;

  assign res_take = res_valid && (!m_tvalid || m_tready);

  stdt_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_data   (s_tdata),
    .mem_req   (mem_req),
    .rd_data   (rd_data),
    .res_valid (res_valid),
    .res_take  (res_take),
    .res       (res)
  );

  stdt_store u_store (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {(OUT_W - $bits(result_t))'(0), res};
    end
  end

endmodule

@@ rtl/core/stdt_chk.sv @@
module stdt_chk
  import stdt_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             m_tvalid,
  input logic             m_tready,
  input logic [OUT_W-1:0] m_tdata
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("output word after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled output word changed");

  a_created_dirty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13:11] == ST_CREATED |-> m_tdata[25])
    else $error("created without dirty");

  a_cleared: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[13:11] == ST_CLEARED |->
      m_tdata[10:0] == '0 && m_tdata[24:14] == '0 && m_tdata[38:26] == '0)
    else $error("clear left counts");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && (m_tdata[13:11] == ST_FOUND || m_tdata[13:11] == ST_CREATED ||
                 m_tdata[13:11] == ST_LOADED) |->
      m_tdata[10:0] != '0 && m_tdata[10:0] <= m_tdata[24:14])
    else $error("position outside table");

endmodule

bind sequence_tail_dedup_table stdt_chk u_chk (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

@@ tb/sv/tb_sequence_tail_dedup_table.sv @@
`timescale 1ns / 1ps

module tb_sequence_tail_dedup_table;
  import stdt_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 8_000_000;
  localparam int unsigned TAIL_WAIT   = 1100;
  localparam int unsigned RAND_WORDS  = 580;

  typedef struct {
    op_t                op;
    logic [CODE_W-1:0]  bases;
    logic [LEN_W-1:0]   len;
    bit                 drain;
  } tail_word_t;

  typedef struct {
    logic [LEN_W-1:0]  len;
    logic [CODE_W-1:0] code;
  } tail_key_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  logic [IN_W-1:0]  s_tdata = '0;   // op, base_bits, tail_length
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  logic [OUT_W-1:0] m_tdata;        // position, status, total_tails, dirty, packed_bytes

  sequence_tail_dedup_table dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
  end

  // expected table state
  logic [ENTRY_W-1:0] tail_mirror [TABLE_ENTRIES];
  int unsigned        n_loaded;
  int unsigned        n_created;
  logic [BYTES_W-1:0] byte_sum;

  tail_word_t   tail_words [$];
  result_t      pending_results [$];
  tail_key_t    seen_tails [$];
  tail_word_t   cur_word;
  int unsigned  n_words;
  int unsigned  n_checked;
  int unsigned  n_errors;
  int unsigned  cyc;

  function automatic result_t tail_table_apply(tail_word_t w);
    result_t            r;
    int unsigned        total;
    int unsigned        hit;
    logic [CODE_W-1:0]  code;
    logic [ENTRY_W-1:0] key;
    r = '0;
    r.status = ST_EMPTY;
    total = n_loaded + n_created;
    case (w.op)
      OP_CLEAR: begin
        n_loaded = 0;
        n_created = 0;
        byte_sum = '0;
        r.status = ST_CLEARED;
      end
      OP_LOAD: begin
        if (n_created != 0 || w.len > MAX_TAIL_BASES) begin
          r.status = ST_REJECTED;
        end else if (total >= TABLE_ENTRIES) begin
          r.status = ST_FULL;
        end else begin
          tail_mirror[total] = {w.len, w.bases};
          byte_sum = byte_sum + BYTES_W'((w.len + 7) >> 2);
          n_loaded++;
          r.position = POS_W'(total + 1);
          r.status = ST_LOADED;
        end
      end
      default: begin
        if (w.len == 0) begin
          r.status = ST_EMPTY;
        end else if (w.len > MAX_TAIL_BASES) begin
          r.status = ST_NOT_FOUND;
        end else begin
          code = w.bases;
          if (w.op == OP_CREATE) code = code & CODE_W'((64'd1 << (2 * w.len)) - 64'd1);
          key = {w.len, code};
          hit = 0;
          for (int unsigned i = 0; i < total && hit == 0; i++) begin
            if (tail_mirror[i] == key) hit = i + 1;
          end
          if (hit != 0) begin
            r.position = POS_W'(hit);
            r.status = ST_FOUND;
          end else if (w.op == OP_FIND) begin
            r.status = ST_NOT_FOUND;
          end else if (total >= TABLE_ENTRIES) begin
            r.status = ST_FULL;
          end else begin
            tail_mirror[total] = key;
            byte_sum = byte_sum + BYTES_W'((w.len + 7) >> 2);
            n_created++;
            r.position = POS_W'(total + 1);
            r.status = ST_CREATED;
          end
        end
      end
    endcase
    r.total_tails = POS_W'(n_loaded + n_created);
    r.dirty = (n_created != 0);
    r.packed_bytes = byte_sum;
    return r;
  endfunction

  function automatic bit idle_roll();
    // the opening stretch of each repeating window runs without idling
    if (cyc % 5000 < 1200) return 1'b0;
    return $urandom_range(0, 99) < 15;
  endfunction

  // driver
  always @(posedge clk) begin
    logic nv;
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) pending_results.push_back(tail_table_apply(cur_word));
      nv = s_tvalid && !s_tready;
      if (!nv) begin
        if (tail_words.size() != 0 && tail_words[0].drain && pending_results.size() == 0)
          void'(tail_words.pop_front());
        if (tail_words.size() != 0 && !tail_words[0].drain && !idle_roll()) begin
          cur_word = tail_words.pop_front();
          s_tdata <= {3'b000, cur_word.len, cur_word.bases, cur_word.op};
          nv = 1'b1;
        end
      end
      s_tvalid <= nv;
    end
  end

  task automatic check_field(string name, int unsigned exp_v, int unsigned act_v);
    if (exp_v != act_v) begin
      n_errors++;
      $display("%0t: %s expected %0d actual %0d", $time, name, exp_v, act_v);
    end
  endtask

  // monitor
  always @(posedge clk) begin
    result_t got;
    result_t exp_r;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = result_t'(m_tdata[$bits(result_t)-1:0]);
        if (pending_results.size() == 0) begin
          n_errors++;
          $display("%0t: unexpected word expected none actual %h", $time, m_tdata);
        end else begin
          exp_r = pending_results.pop_front();
          check_field("position", exp_r.position, got.position);
          check_field("status", exp_r.status, got.status);
          check_field("total_tails", exp_r.total_tails, got.total_tails);
          check_field("dirty", exp_r.dirty, got.dirty);
          check_field("packed_bytes", exp_r.packed_bytes, got.packed_bytes);
          n_checked++;
        end
      end
      m_tready <= !idle_roll();
    end
  end

  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic add_word(op_t op, logic [CODE_W-1:0] b, logic [LEN_W-1:0] l);
    tail_word_t w;
    w.op = op;
    w.bases = b;
    w.len = l;
    w.drain = 1'b0;
    tail_words.push_back(w);
    n_words++;
  endtask

  task automatic add_drain();
    tail_word_t w;
    w.op = OP_CLEAR;
    w.bases = '0;
    w.len = '0;
    w.drain = 1'b1;
    tail_words.push_back(w);
  endtask

  function automatic logic [CODE_W-1:0] rand_bases();
    return CODE_W'({$urandom, $urandom});
  endfunction

  function automatic logic [LEN_W-1:0] rand_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return LEN_W'($urandom_range(1, 4));
    if (r < 85) return LEN_W'($urandom_range(5, MAX_TAIL_BASES));
    if (r < 93) return '0;
    return LEN_W'($urandom_range(MAX_TAIL_BASES + 1, 31));
  endfunction

  function automatic logic [CODE_W-1:0] trim(logic [CODE_W-1:0] b, logic [LEN_W-1:0] l);
    return b & CODE_W'((64'd1 << (2 * l)) - 64'd1);
  endfunction

  task automatic remember(logic [LEN_W-1:0] l, logic [CODE_W-1:0] b);
    tail_key_t k;
    k.len = l;
    k.code = b;
    seen_tails.push_back(k);
  endtask

  task automatic random_segment();
    int unsigned       n_ops;
    int unsigned       r;
    logic [LEN_W-1:0]  l;
    logic [CODE_W-1:0] b;
    tail_key_t         k;
    if ($urandom_range(0, 3) != 0) begin
      add_word(OP_CLEAR, rand_bases(), rand_len());
      seen_tails.delete();
    end
    repeat ($urandom_range(0, 6)) begin
      l = rand_len();
      b = ($urandom_range(0, 1)) ? rand_bases() : trim(rand_bases(), l);
      add_word(OP_LOAD, b, l);
      remember(l, b);
    end
    n_ops = $urandom_range(8, 40);
    repeat (n_ops) begin
      r = $urandom_range(0, 99);
      if (seen_tails.size() != 0 && $urandom_range(0, 99) < 55) begin
        k = seen_tails[$urandom_range(0, seen_tails.size() - 1)];
        l = k.len;
        b = k.code;
        if ($urandom_range(0, 3) == 0) b = b | (rand_bases() & ~trim('1, l));
      end else begin
        l = rand_len();
        b = rand_bases();
      end
      if (r < 42) begin
        add_word(OP_CREATE, b, l);
        if (l != 0 && l <= MAX_TAIL_BASES) remember(l, trim(b, l));
      end else if (r < 75) begin
        add_word(OP_FIND, b, l);
      end else if (r < 95) begin
        add_word(OP_LOAD, b, l);
        remember(l, b);
      end else begin
        add_word(OP_CLEAR, b, l);
        seen_tails.delete();
      end
    end
  endtask

  initial begin
    logic [LEN_W-1:0]  l;
    logic [CODE_W-1:0] b;
    logic [CODE_W-1:0] last_b;
    logic [LEN_W-1:0]  last_l;
    int unsigned       seg;
    n_loaded = 0;
    n_created = 0;
    byte_sum = '0;
    n_words = 0;
    n_checked = 0;
    n_errors = 0;
    cyc = 0;

    // directed
    add_word(OP_FIND, 46'h15, 5'd5);                        // empty table
    add_word(OP_CREATE, '1, 5'd0);                          // empty tail
    add_word(OP_FIND, '1, 5'd24);                           // overlong
    add_word(OP_CREATE, '1, 5'd31);
    add_word(OP_LOAD, '1, 5'd0);                            // zero-length load
    add_word(OP_LOAD, '1, 5'd23);
    add_word(OP_LOAD, 46'h2AAA_AAAA_A3C5, 5'd5);            // junk above the tail kept
    add_word(OP_LOAD, '0, 5'd26);                           // overlong load
    add_word(OP_FIND, 46'h2AAA_AAAA_A3C5, 5'd5);
    add_word(OP_CREATE, 46'h2AAA_AAAA_A3C5, 5'd5);          // masked, so new
    add_word(OP_LOAD, '0, 5'd0);
    add_word(OP_CREATE, '1, 5'd23);
    add_word(OP_CREATE, '0, 5'd1);
    add_word(OP_CREATE, 46'h3, 5'd1);
    add_word(OP_CREATE, 46'h3FFF_FFFF_FFFF, 5'd1);          // hits after masking
    add_word(OP_LOAD, '0, 5'd1);                            // load after create
    add_word(OP_FIND, 46'h2, 5'd1);
    add_word(OP_FIND, 46'h3C5, 5'd5);
    add_word(OP_CLEAR, '1, '1);
    add_word(OP_LOAD, 46'h1, 5'd1);
    add_word(OP_FIND, '0, 5'd0);
    add_word(OP_CREATE, '0, 5'd23);
    add_word(OP_FIND, '0, 5'd23);
    add_drain();

    seg = 0;
    while (n_words < 23 + RAND_WORDS) begin
      random_segment();
      seg++;
      if (seg % 6 == 3) add_drain();
    end

    // full table
    add_drain();
    add_word(OP_CLEAR, '0, '0);
    last_b = '0;
    last_l = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      l = LEN_W'($urandom_range(0, MAX_TAIL_BASES));
      b = ($urandom_range(0, 3) == 0) ? rand_bases() : trim(rand_bases(), l);
      if (i == TABLE_ENTRIES - 1) begin
        l = 5'd17;
        b = trim(rand_bases(), l);
      end
      add_word(OP_LOAD, b, l);
      last_b = b;
      last_l = l;
    end
    add_word(OP_LOAD, '0, 5'd3);
    add_word(OP_FIND, last_b, last_l);
    add_word(OP_CREATE, last_b, last_l);
    add_word(OP_CREATE, rand_bases(), 5'd23);
    add_word(OP_FIND, rand_bases(), 5'd22);
    add_word(OP_LOAD, '0, 5'd30);
    add_word(OP_CLEAR, '0, '0);
    add_word(OP_CREATE, last_b, last_l);

    while (rst) @(posedge clk);
    while (n_checked < n_words) @(posedge clk);
    repeat (TAIL_WAIT) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
